// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/bpt_pkg.sv -----
package bpt_pkg;

	localparam int COORD_BITS_DEF       = 16;
	localparam int WEIGHT_FRAC_BITS_DEF = 14;
	localparam int OUT_BITS             = 16;
	localparam int QBITS                = OUT_BITS - 1;

	localparam logic signed [OUT_BITS-1:0] W_MAX = 16'sh7FFF;
	localparam logic signed [OUT_BITS-1:0] W_MIN = 16'sh8000;

	// cross products and areas wrap at 64 bits
	function automatic int prod_bits(input int cb);
		return (2 * cb + 3 > 64) ? 64 : 2 * cb + 3;
	endfunction

endpackage

// ----- sv/bpt_in_if.sv -----
interface bpt_in_if #(
	parameter int COORD_BITS = bpt_pkg::COORD_BITS_DEF
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
	logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
	logic signed [COORD_BITS-1:0] c_x, c_y, c_z;
	logic signed [COORD_BITS-1:0] p_x, p_y, p_z;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z,
		output ready
	);
endinterface

// ----- sv/bpt_out_if.sv -----
interface bpt_out_if ();
	logic                                  valid;
	logic                                  ready;
	logic signed [bpt_pkg::OUT_BITS-1:0]   weight_u;
	logic signed [bpt_pkg::OUT_BITS-1:0]   weight_v;
	logic signed [bpt_pkg::OUT_BITS-1:0]   weight_w;
	logic                                  inside_res;
	logic                                  degenerate;

	modport source (
		output valid, weight_u, weight_v, weight_w, inside_res, degenerate,
		input  ready
	);
	modport sink (
		input  valid, weight_u, weight_v, weight_w, inside_res, degenerate,
		output ready
	);
endinterface

// ----- sv/bpt_geom.sv -----
module bpt_geom #(
	parameter int COORD_BITS = bpt_pkg::COORD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	bpt_in_if.sink                                   query,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [bpt_pkg::prod_bits(COORD_BITS)-1:0] mag_u,
	output logic [bpt_pkg::prod_bits(COORD_BITS)-1:0] mag_v,
	output logic [bpt_pkg::prod_bits(COORD_BITS)-1:0] mag_d,
	output logic                                     sgn_u,
	output logic                                     sgn_v,
	output logic                                     degen
);
	import bpt_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int EW = CB + 1;
	localparam int MW = 2 * CB + 2;
	localparam int DW = MW + 1;
	localparam int PW = prod_bits(CB);

	typedef struct packed {
		logic signed [CB-1:0] x, y, z;
	} vec_t;
	typedef struct packed {
		vec_t a, b, c, p;
	} tri_t;
	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

	logic [8:1] vld_s;
	logic [8:1] en_s;

	always_comb begin
		en_s[8] = !vld_s[8] || out_ready;
		for (int k = 7; k >= 1; k--) begin
			en_s[k] = !vld_s[k] || en_s[k+1];
		end
	end

	assign query.ready = en_s[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en_s[1]) begin
				vld_s[1] <= query.valid;
			end
			for (int k = 2; k <= 8; k++) begin
				if (en_s[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// s1: edges
	tri_t tri_s1;
	logic signed [EW-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;

	always_ff @(posedge clk) begin
		if (en_s[1]) begin
			tri_s1 <= '{a: '{query.a_x, query.a_y, query.a_z},
			            b: '{query.b_x, query.b_y, query.b_z},
			            c: '{query.c_x, query.c_y, query.c_z},
			            p: '{query.p_x, query.p_y, query.p_z}};
			e1x_s1 <= EW'(query.b_x) - EW'(query.a_x);
			e1y_s1 <= EW'(query.b_y) - EW'(query.a_y);
			e1z_s1 <= EW'(query.b_z) - EW'(query.a_z);
			e2x_s1 <= EW'(query.c_x) - EW'(query.a_x);
			e2y_s1 <= EW'(query.c_y) - EW'(query.a_y);
			e2z_s1 <= EW'(query.c_z) - EW'(query.a_z);
		end
	end

	// s2: cross product terms
	tri_t tri_s2;
	logic signed [MW-1:0] pr_s2 [6];

	always_ff @(posedge clk) begin
		if (en_s[2]) begin
			tri_s2   <= tri_s1;
			pr_s2[0] <= MW'(e1y_s1) * MW'(e2z_s1);
			pr_s2[1] <= MW'(e1z_s1) * MW'(e2y_s1);
			pr_s2[2] <= MW'(e1z_s1) * MW'(e2x_s1);
			pr_s2[3] <= MW'(e1x_s1) * MW'(e2z_s1);
			pr_s2[4] <= MW'(e1x_s1) * MW'(e2y_s1);
			pr_s2[5] <= MW'(e1y_s1) * MW'(e2x_s1);
		end
	end

	// s3: normal
	tri_t tri_s3;
	logic [PW-1:0] nx_s3, ny_s3, nz_s3;

	always_ff @(posedge clk) begin
		if (en_s[3]) begin
			tri_s3 <= tri_s2;
			nx_s3  <= PW'(DW'(pr_s2[0]) - DW'(pr_s2[1]));
			ny_s3  <= PW'(DW'(pr_s2[2]) - DW'(pr_s2[3]));
			nz_s3  <= PW'(DW'(pr_s2[4]) - DW'(pr_s2[5]));
		end
	end

	// s4: normal magnitudes
	tri_t tri_s4;
	logic [PW-1:0] nx_s4, ny_s4, nz_s4;
	logic [PW-1:0] mx_s4, my_s4, mz_s4;

	always_ff @(posedge clk) begin
		if (en_s[4]) begin
			tri_s4 <= tri_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			nz_s4  <= nz_s3;
			mx_s4  <= nx_s3[PW-1] ? PW'(0) - nx_s3 : nx_s3;
			my_s4  <= ny_s3[PW-1] ? PW'(0) - ny_s3 : ny_s3;
			mz_s4  <= nz_s3[PW-1] ? PW'(0) - nz_s3 : nz_s3;
		end
	end

	// s5: dominant axis, projection
	axis_t                axis;
	logic signed [CB-1:0] pi, pj, ai, aj, bi, bj, ci, cj;
	logic [PW-1:0]        d_sel;

	always_comb begin
		if (mx_s4 >= my_s4 && mx_s4 >= mz_s4) begin
			axis = AX_X;
		end else if (my_s4 >= mx_s4 && my_s4 >= mz_s4) begin
			axis = AX_Y;
		end else begin
			axis = AX_Z;
		end
		unique case (axis)
			AX_X: begin
				pi = tri_s4.p.y; pj = tri_s4.p.z; ai = tri_s4.a.y; aj = tri_s4.a.z;
				bi = tri_s4.b.y; bj = tri_s4.b.z; ci = tri_s4.c.y; cj = tri_s4.c.z;
				d_sel = nx_s4;
			end
			AX_Y: begin
				pi = tri_s4.p.x; pj = tri_s4.p.z; ai = tri_s4.a.x; aj = tri_s4.a.z;
				bi = tri_s4.b.x; bj = tri_s4.b.z; ci = tri_s4.c.x; cj = tri_s4.c.z;
				d_sel = PW'(0) - ny_s4;
			end
			default: begin
				pi = tri_s4.p.x; pj = tri_s4.p.y; ai = tri_s4.a.x; aj = tri_s4.a.y;
				bi = tri_s4.b.x; bj = tri_s4.b.y; ci = tri_s4.c.x; cj = tri_s4.c.y;
				d_sel = nz_s4;
			end
		endcase
	end

	logic signed [EW-1:0] du_s5 [4];
	logic signed [EW-1:0] dv_s5 [4];
	logic [PW-1:0]        d_s5;

	always_ff @(posedge clk) begin
		if (en_s[5]) begin
			du_s5[0] <= EW'(pi) - EW'(bi);
			du_s5[1] <= EW'(bj) - EW'(cj);
			du_s5[2] <= EW'(bi) - EW'(ci);
			du_s5[3] <= EW'(pj) - EW'(bj);
			dv_s5[0] <= EW'(pi) - EW'(ci);
			dv_s5[1] <= EW'(cj) - EW'(aj);
			dv_s5[2] <= EW'(ci) - EW'(ai);
			dv_s5[3] <= EW'(pj) - EW'(cj);
			d_s5     <= d_sel;
		end
	end

	// s6: area terms
	logic signed [MW-1:0] pu_s6 [2];
	logic signed [MW-1:0] pv_s6 [2];
	logic [PW-1:0]        d_s6;

	always_ff @(posedge clk) begin
		if (en_s[6]) begin
			pu_s6[0] <= MW'(du_s5[0]) * MW'(du_s5[1]);
			pu_s6[1] <= MW'(du_s5[2]) * MW'(du_s5[3]);
			pv_s6[0] <= MW'(dv_s5[0]) * MW'(dv_s5[1]);
			pv_s6[1] <= MW'(dv_s5[2]) * MW'(dv_s5[3]);
			d_s6     <= d_s5;
		end
	end

	// s7: doubled areas
	logic [PW-1:0] nu_s7, nv_s7, d_s7;

	always_ff @(posedge clk) begin
		if (en_s[7]) begin
			nu_s7 <= PW'(DW'(pu_s6[0]) - DW'(pu_s6[1]));
			nv_s7 <= PW'(DW'(pv_s6[0]) - DW'(pv_s6[1]));
			d_s7  <= d_s6;
		end
	end

	// s8: sign and magnitude for the divider
	logic [PW-1:0] mu_s8, mv_s8, md_s8;
	logic          su_s8, sv_s8, dg_s8;

	always_ff @(posedge clk) begin
		if (en_s[8]) begin
			mu_s8 <= nu_s7[PW-1] ? PW'(0) - nu_s7 : nu_s7;
			mv_s8 <= nv_s7[PW-1] ? PW'(0) - nv_s7 : nv_s7;
			md_s8 <= d_s7[PW-1] ? PW'(0) - d_s7 : d_s7;
			su_s8 <= nu_s7[PW-1] ^ d_s7[PW-1];
			sv_s8 <= nv_s7[PW-1] ^ d_s7[PW-1];
			dg_s8 <= (d_s7 == '0);
		end
	end

	assign out_valid = vld_s[8];
	assign mag_u     = mu_s8;
	assign mag_v     = mv_s8;
	assign mag_d     = md_s8;
	assign sgn_u     = su_s8;
	assign sgn_v     = sv_s8;
	assign degen     = dg_s8;

endmodule

// ----- sv/bpt_div.sv -----
module bpt_div #(
	parameter int COORD_BITS       = bpt_pkg::COORD_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = bpt_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [bpt_pkg::prod_bits(COORD_BITS)-1:0] mag_u,
	input  logic [bpt_pkg::prod_bits(COORD_BITS)-1:0] mag_v,
	input  logic [bpt_pkg::prod_bits(COORD_BITS)-1:0] mag_d,
	input  logic                                     sgn_u,
	input  logic                                     sgn_v,
	input  logic                                     degen_in,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [bpt_pkg::OUT_BITS-1:0]      weight_u,
	output logic signed [bpt_pkg::OUT_BITS-1:0]      weight_v,
	output logic                                     degen
);
	import bpt_pkg::*;

	localparam int PW  = prod_bits(COORD_BITS);
	localparam int F   = WEIGHT_FRAC_BITS;
	localparam int QB  = QBITS;
	localparam int SHW = (F > QB) ? F : QB;
	localparam int XW  = PW + SHW + 1;
	localparam int NS  = QB + 2;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] en_s;

	always_comb begin
		en_s[NS-1] = !vld_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en_s[k] = !vld_s[k] || en_s[k+1];
		end
	end

	assign in_ready = en_s[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en_s[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en_s[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	logic [PW-1:0] num [2];
	logic          sgn [2];

	assign num[0] = mag_u;
	assign num[1] = mag_v;
	assign sgn[0] = sgn_u;
	assign sgn[1] = sgn_v;

	logic [XW-1:0] rem_s [QB+1][2];
	logic [QB-1:0] quo_s [QB+1][2];
	logic          ovf_s [QB+1][2];
	logic          sgn_s [QB+1][2];
	logic [PW-1:0] den_s [QB+1];
	logic          dgn_s [QB+1];

	// step 0: scale numerator, flag quotients at or above full scale
	always_ff @(posedge clk) begin
		if (en_s[0]) begin
			for (int l = 0; l < 2; l++) begin
				rem_s[0][l] <= XW'(num[l]) << F;
				ovf_s[0][l] <= (XW'(num[l]) << F) >= (XW'(mag_d) << QB);
				quo_s[0][l] <= '0;
				sgn_s[0][l] <= sgn[l];
			end
			den_s[0] <= mag_d;
			dgn_s[0] <= degen_in;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [XW-1:0] sub;

		assign sub = XW'(den_s[k-1]) << (QB - k);

		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				for (int l = 0; l < 2; l++) begin
					if (rem_s[k-1][l] >= sub) begin
						rem_s[k][l] <= rem_s[k-1][l] - sub;
						quo_s[k][l] <= quo_s[k-1][l] | (QB'(1) << (QB - k));
					end else begin
						rem_s[k][l] <= rem_s[k-1][l];
						quo_s[k][l] <= quo_s[k-1][l];
					end
					ovf_s[k][l] <= ovf_s[k-1][l];
					sgn_s[k][l] <= sgn_s[k-1][l];
				end
				den_s[k] <= den_s[k-1];
				dgn_s[k] <= dgn_s[k-1];
			end
		end
	end

	// round half away from zero, then saturate
	logic [QB:0]                  mq  [2];
	logic signed [OUT_BITS-1:0]   res [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mq[l] = (QB+1)'(quo_s[QB][l]) +
			        (QB+1)'({rem_s[QB][l], 1'b0} >= {1'b0, XW'(den_s[QB])});
			if (dgn_s[QB]) begin
				res[l] = '0;
			end else if (ovf_s[QB][l]) begin
				res[l] = sgn_s[QB][l] ? W_MIN : W_MAX;
			end else if (!sgn_s[QB][l]) begin
				res[l] = mq[l][QB] ? W_MAX : OUT_BITS'(mq[l]);
			end else begin
				res[l] = OUT_BITS'(0) - OUT_BITS'(mq[l]);
			end
		end
	end

	logic signed [OUT_BITS-1:0] wt_s [2];
	logic                       dgn_f_s;

	always_ff @(posedge clk) begin
		if (en_s[NS-1]) begin
			wt_s[0] <= res[0];
			wt_s[1] <= res[1];
			dgn_f_s <= dgn_s[QB];
		end
	end

	assign out_valid = vld_s[NS-1];
	assign weight_u  = wt_s[0];
	assign weight_v  = wt_s[1];
	assign degen     = dgn_f_s;

endmodule

// ----- sv/barycentric_point_in_triangle.sv -----
// channel  dir  fields                                          word
// query    in   a_x..p_z, 12 x COORD_BITS signed Q8.8           one triangle + point
// result   out  weight_u/v/w Q2.14, inside_res, degenerate      one test result
//
// One word accepted per cycle unless back-pressure reaches the input; stages: 8 geometry, 17 divider, 1 output.
// The bit-per-stage divider computes both weights in parallel lanes.
// arst_n clears all valid bits; payload registers are not reset.
// Stalls back-pressure stage by stage; empty stages still fill while the output waits.
module barycentric_point_in_triangle #(
	parameter int COORD_BITS       = bpt_pkg::COORD_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = bpt_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bpt_in_if.sink     query,
	bpt_out_if.source  result
);
	import bpt_pkg::*;
	`include "assert_macros.svh"

	localparam int PW = prod_bits(COORD_BITS);
	localparam int F  = WEIGHT_FRAC_BITS;
	localparam int SW = (F + 3 > OUT_BITS + 2) ? F + 3 : OUT_BITS + 2;
	localparam logic signed [SW-1:0] One = SW'(1) << F;

	logic          g_valid, g_ready;
	logic [PW-1:0] g_mu, g_mv, g_md;
	logic          g_su, g_sv, g_dg;

	bpt_geom #(
		.COORD_BITS (COORD_BITS)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.out_valid (g_valid),
		.out_ready (g_ready),
		.mag_u     (g_mu),
		.mag_v     (g_mv),
		.mag_d     (g_md),
		.sgn_u     (g_su),
		.sgn_v     (g_sv),
		.degen     (g_dg)
	);

	logic                       d_valid, en_o, d_dg;
	logic signed [OUT_BITS-1:0] d_u, d_v;

	bpt_div #(
		.COORD_BITS       (COORD_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (g_valid),
		.in_ready  (g_ready),
		.mag_u     (g_mu),
		.mag_v     (g_mv),
		.mag_d     (g_md),
		.sgn_u     (g_su),
		.sgn_v     (g_sv),
		.degen_in  (g_dg),
		.out_valid (d_valid),
		.out_ready (en_o),
		.weight_u  (d_u),
		.weight_v  (d_v),
		.degen     (d_dg)
	);

	logic                       out_valid_q;
	logic signed [OUT_BITS-1:0] wu_q, wv_q, ww_q;
	logic                       ins_q, dgn_q;

	logic signed [SW-1:0]       wsum;
	logic signed [OUT_BITS-1:0] w_sat;
	logic                       in_tri;

	assign en_o = !out_valid_q || result.ready;

	always_comb begin
		wsum = One - SW'(d_u) - SW'(d_v);
		if (d_dg) begin
			w_sat = '0;
		end else if (wsum > SW'(W_MAX)) begin
			w_sat = W_MAX;
		end else if (wsum < SW'(W_MIN)) begin
			w_sat = W_MIN;
		end else begin
			w_sat = OUT_BITS'(wsum);
		end
		in_tri = !d_dg && d_v > 0 && w_sat > 0 && (SW'(d_v) + SW'(w_sat) <= One);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			wu_q  <= d_u;
			wv_q  <= d_v;
			ww_q  <= w_sat;
			ins_q <= in_tri;
			dgn_q <= d_dg;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.weight_u   = wu_q;
	assign result.weight_v   = wv_q;
	assign result.weight_w   = ww_q;
	assign result.inside_res = ins_q;
	assign result.degenerate = dgn_q;

	`ASSERT_IMPL(a_degen_zero, clk, arst_n, out_valid_q && dgn_q, wu_q == '0 && wv_q == '0 && ww_q == '0 && !ins_q, "degenerate word with nonzero weights")
	`ASSERT_IMPL(a_inside_sum, clk, arst_n, out_valid_q && ins_q, (SW'(wu_q) + SW'(wv_q) + SW'(ww_q)) == One, "inside word whose weights do not sum to one")
	`ASSERT_NEXT(a_capture, clk, arst_n, d_valid && en_o, out_valid_q, "divider word lost at output register")

endmodule
